[sv/mrif_pkg.sv]
package mrif_pkg;

    localparam int DATA_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 13;
    localparam int TICK_W     = 16;
    localparam int PREFIX_LEN = 7;
    localparam int PFX_AW     = 3;
    localparam int SMS_LEN    = 6;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int ADDR_W     = 4;

    // frame end status codes
    localparam logic [STATUS_W-1:0] ST_GAP     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOREPLY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SMS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // result kind codes (carried on tuser)
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_REPLY_TICKS  = 2'd0;
    localparam logic [1:0] REG_GAP_TICKS    = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;
    localparam logic [1:0] REG_SMS_CHECK    = 2'd3;

    // register reset values
    localparam logic [TICK_W-1:0] RST_REPLY_TICKS  = 16'd1000;
    localparam logic [TICK_W-1:0] RST_GAP_TICKS    = 16'd40;
    localparam logic [LEN_W-1:0]  RST_LENGTH_LIMIT = 13'd1024;

    // CR LF "ERROR", entry 0 first
    localparam logic [PREFIX_LEN-1:0][DATA_W-1:0] ERR_PREFIX =
        {8'h52, 8'h4F, 8'h52, 8'h52, 8'h45, 8'h0A, 8'h0D};
    // CR LF "+CMT", entry 0 first
    localparam logic [SMS_LEN-1:0][DATA_W-1:0] SMS_PREFIX =
        {8'h54, 8'h4D, 8'h43, 8'h2B, 8'h0A, 8'h0D};

    typedef struct packed {
        logic [TICK_W-1:0] reply_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [LEN_W-1:0]  length_limit;
        logic              sms_check;
    } cfg_t;

    // one classified request: optional data byte, optional frame end
    typedef struct packed {
        logic                has_data;
        logic [DATA_W-1:0]   data_byte;
        logic                has_end;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    frame_length;
    } q_entry_t;

endpackage

[sv/mrif_front.sv]
module mrif_front #(
    parameter int LIMIT_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mrif_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            has_byte,
    input  logic [mrif_pkg::DATA_W-1:0]     rx_byte,
    input  logic                            q_full,
    output logic                            push,
    output mrif_pkg::q_entry_t              push_entry
);

    localparam int CMP_W = 17;

    logic                            receiving_reg, receiving_next;
    logic [mrif_pkg::TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [LIMIT_BITS-1:0]           byte_count_reg, byte_count_next;
    logic [mrif_pkg::DATA_W-1:0]     prefix_reg [mrif_pkg::PREFIX_LEN];

    logic                            accept;
    logic [mrif_pkg::TICK_W-1:0]     tick_inc;
    logic [mrif_pkg::TICK_W-1:0]     tick_limit;
    logic                            tick_end;
    logic [LIMIT_BITS-1:0]           cnt_inc;
    logic [CMP_W-1:0]                cnt_ext;
    logic [CMP_W-1:0]                old_ext;
    logic [mrif_pkg::LEN_W-1:0]      lim;
    logic [mrif_pkg::DATA_W-1:0]     view [mrif_pkg::PREFIX_LEN];
    logic                            err_hit;
    logic                            sms_hit;
    logic                            pfx_ok;
    logic                            byte_end;
    logic [mrif_pkg::STATUS_W-1:0]   byte_status;
    logic                            pfx_wr;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // empty tick: saturating tick count against the active limit
    assign tick_inc   = (tick_count_reg != '1) ? tick_count_reg + 16'd1 : tick_count_reg;
    assign tick_limit = receiving_reg ? cfg.gap_ticks : cfg.reply_ticks;
    assign tick_end   = tick_inc >= tick_limit;

    // byte: saturating count, limit of zero acts as one
    assign cnt_inc = (byte_count_reg != '1) ? byte_count_reg + LIMIT_BITS'(1)
                                            : byte_count_reg;
    assign cnt_ext = CMP_W'(cnt_inc);
    assign old_ext = CMP_W'(byte_count_reg);
    assign lim     = (cfg.length_limit == '0) ? mrif_pkg::LEN_W'(1) : cfg.length_limit;
    assign pfx_wr  = old_ext < CMP_W'(mrif_pkg::PREFIX_LEN);

    // prefix store as it stands after this byte is written
    always_comb
    begin
        for (int i = 0; i < mrif_pkg::PREFIX_LEN; i++)
        begin
            view[i] = (pfx_wr && byte_count_reg == LIMIT_BITS'(i)) ? rx_byte : prefix_reg[i];
        end
    end

    always_comb
    begin
        err_hit = 1'b1;
        sms_hit = cfg.sms_check;
        for (int i = 0; i < mrif_pkg::PREFIX_LEN; i++)
        begin
            if (view[i] != mrif_pkg::ERR_PREFIX[i])
            begin
                err_hit = 1'b0;
            end
        end
        for (int i = 0; i < mrif_pkg::SMS_LEN; i++)
        begin
            if (view[i] != mrif_pkg::SMS_PREFIX[i])
            begin
                sms_hit = 1'b0;
            end
        end
    end

    assign pfx_ok = receiving_reg && (cnt_ext >= CMP_W'(mrif_pkg::PREFIX_LEN));

    // frame end decision for a byte; prefix match wins over the limit
    always_comb
    begin
        byte_end    = 1'b0;
        byte_status = mrif_pkg::ST_GAP;
        if (pfx_ok && err_hit)
        begin
            byte_end    = 1'b1;
            byte_status = mrif_pkg::ST_ERROR;
        end
        else if (pfx_ok && sms_hit)
        begin
            byte_end    = 1'b1;
            byte_status = mrif_pkg::ST_SMS;
        end
        else if (cnt_ext >= CMP_W'(lim) || cnt_inc == '1)
        begin
            byte_end    = 1'b1;
            byte_status = mrif_pkg::ST_FULL;
        end
    end

    // queue request and next state
    always_comb
    begin
        receiving_next  = receiving_reg;
        tick_count_next = tick_count_reg;
        byte_count_next = byte_count_reg;
        push            = 1'b0;
        push_entry      = '0;
        if (accept)
        begin
            if (has_byte)
            begin
                push                    = 1'b1;
                push_entry.has_data     = 1'b1;
                push_entry.data_byte    = rx_byte;
                push_entry.has_end      = byte_end;
                push_entry.status       = byte_status;
                push_entry.frame_length = cnt_ext[mrif_pkg::LEN_W-1:0];
                tick_count_next         = '0;
                receiving_next          = !byte_end;
                byte_count_next         = byte_end ? '0 : cnt_inc;
            end
            else if (tick_end)
            begin
                push                    = 1'b1;
                push_entry.has_end      = 1'b1;
                push_entry.status       = receiving_reg ? mrif_pkg::ST_GAP
                                                        : mrif_pkg::ST_NOREPLY;
                push_entry.frame_length = old_ext[mrif_pkg::LEN_W-1:0];
                receiving_next          = 1'b0;
                tick_count_next         = '0;
                byte_count_next         = '0;
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            tick_count_reg <= '0;
            byte_count_reg <= '0;
        end
        else
        begin
            receiving_reg  <= receiving_next;
            tick_count_reg <= tick_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // first bytes of the frame, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && has_byte && pfx_wr)
        begin
            prefix_reg[byte_count_reg[mrif_pkg::PFX_AW-1:0]] <= rx_byte;
        end
    end

endmodule

[sv/mrif_queue.sv]
module mrif_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mrif_pkg::q_entry_t push_entry,
    input  logic               pop,
    output mrif_pkg::q_entry_t head,
    output logic               q_valid,
    output logic               q_full
);

    mrif_pkg::q_entry_t          slot_reg [mrif_pkg::Q_DEPTH];
    logic [mrif_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mrif_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mrif_pkg::Q_AW:0]     count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == (mrif_pkg::Q_AW+1)'(mrif_pkg::Q_DEPTH);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/mrif_back.sv]
module mrif_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  mrif_pkg::q_entry_t                  head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    logic                  tvalid_reg, tvalid_next;
    logic [23:0]           tdata_reg, tdata_next;
    logic                  tuser_reg, tuser_next;
    logic                  tlast_reg, tlast_next;
    logic                  phase_reg, phase_next;
    logic                  out_free;

    assign out_free = !tvalid_reg || m_tready;

    // expand one request into a data result and/or an end result
    always_comb
    begin
        tvalid_next = tvalid_reg && !m_tready;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        tlast_next  = tlast_reg;
        phase_next  = phase_reg;
        pop         = 1'b0;
        if (out_free && q_valid)
        begin
            tvalid_next = 1'b1;
            if (head.has_data && !phase_reg)
            begin
                tdata_next = {head.frame_length, mrif_pkg::ST_GAP, head.data_byte};
                tuser_next = mrif_pkg::KIND_DATA;
                tlast_next = !head.has_end;
                phase_next = head.has_end;
                pop        = !head.has_end;
            end
            else
            begin
                tdata_next = {head.frame_length, head.status, 8'h00};
                tuser_next = mrif_pkg::KIND_END;
                tlast_next = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    // end result pending means its request is still at the queue head
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_valid && head.has_end)
        else $error("end phase without a pending request");

    // a frame end result is always the last one of its request
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mrif_pkg::KIND_END |-> m_tlast)
        else $error("frame end result without tlast");

    // a data byte that ends a frame is followed at once by the end result
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == mrif_pkg::KIND_DATA && !m_tlast
        |=> m_tvalid && m_tuser == mrif_pkg::KIND_END)
        else $error("missing frame end after data byte");

endmodule

[sv/modem_reply_idle_framer.sv]
// With the queue empty and the output free, an accepted request is written into the queue
// and then into the output register, from which m_tvalid and the result are driven.
// Throughput: one request per cycle while the queue is not full (s_tready is low when it
// is); a byte that ends a frame gives a data result, then an end result, on the output,
// absorbed by a four-entry request queue. Empty ticks that end nothing produce no result.
// Reset (rst_n, async, active low): registers to defaults, framer waits for the
// first byte, queue and output empty.
module modem_reply_idle_framer #(
    parameter int LIMIT_BITS = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input poll stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic                          s_tuser,   // [0] has_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [7:0] data_byte, [10:8] status,
                                                     // [23:11] frame_length
    output logic                          m_tuser,   // [0] kind
    output logic                          m_tlast,   // last result of the request
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrif_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    mrif_pkg::cfg_t      cfg_reg;
    mrif_pkg::cfg_t      cfg_next;
    logic [1:0]          reg_idx;
    logic                wr_en;
    logic                q_full;
    logic                q_valid;
    logic                push;
    logic                pop;
    mrif_pkg::q_entry_t  push_entry;
    mrif_pkg::q_entry_t  head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mrif_pkg::REG_REPLY_TICKS:  cfg_next.reply_ticks  = pwdata[15:0];
                mrif_pkg::REG_GAP_TICKS:    cfg_next.gap_ticks    = pwdata[15:0];
                mrif_pkg::REG_LENGTH_LIMIT: cfg_next.length_limit = pwdata[12:0];
                mrif_pkg::REG_SMS_CHECK:    cfg_next.sms_check    = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reply_ticks  <= mrif_pkg::RST_REPLY_TICKS;
            cfg_reg.gap_ticks    <= mrif_pkg::RST_GAP_TICKS;
            cfg_reg.length_limit <= mrif_pkg::RST_LENGTH_LIMIT;
            cfg_reg.sms_check    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_idx)
            mrif_pkg::REG_REPLY_TICKS:  prdata = {16'h0000, cfg_reg.reply_ticks};
            mrif_pkg::REG_GAP_TICKS:    prdata = {16'h0000, cfg_reg.gap_ticks};
            mrif_pkg::REG_LENGTH_LIMIT: prdata = {19'h00000, cfg_reg.length_limit};
            mrif_pkg::REG_SMS_CHECK:    prdata = {31'h00000000, cfg_reg.sms_check};
            default:                    prdata = '0;
        endcase
    end

    mrif_front #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .has_byte   (s_tuser),
        .rx_byte    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mrif_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_valid    (q_valid),
        .q_full     (q_full)
    );

    mrif_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
